>>> sv/spa_pkg.sv
// Shared types and constants for the sparse polynomial accumulator.
package spa_pkg;

    // Table size and the widths that follow from it.
    localparam int MAX_TERMS = 32;
    localparam int CNT_W     = $clog2(MAX_TERMS + 1);
    localparam int IDX_W     = $clog2(MAX_TERMS);
    localparam int COEF_W    = 32;
    localparam int EXP_W     = 16;
    localparam int MODE_W    = 2;
    localparam int STATUS_W  = 3;

    // Item operation codes.
    typedef enum logic [MODE_W-1:0] {
        MODE_ADD   = 2'd0,
        MODE_CLEAR = 2'd1,
        MODE_DUMP  = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_ADDED   = 3'd0,
        STAT_FULL    = 3'd1,
        STAT_CLEARED = 3'd2,
        STAT_TERM    = 3'd3,
        STAT_EMPTY   = 3'd4
    } t_status;

    // One stored term.
    typedef struct packed {
        logic [EXP_W-1:0]  expo;
        logic [COEF_W-1:0] coef;
    } t_term;

    // Access request to the term memory.
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_term            wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } t_mem_req;

    // One result item handed to the output stage.
    typedef struct packed {
        t_status           status;
        logic [COEF_W-1:0] coef;
        logic [EXP_W-1:0]  expo;
        logic              last;
    } t_result;

endpackage

>>> sv/spa_term_mem.sv
// Term table memory: one write port and one registered read port.
module spa_term_mem (
    input  logic              i_clk,
    input  spa_pkg::t_mem_req i_req,
    output spa_pkg::t_term    o_rdata
);
    import spa_pkg::*;

    t_term r_mem [MAX_TERMS];
    t_term r_rdata;

    // Write and read; read data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/spa_out_stage.sv
// Output register that holds one result item until it is taken.
module spa_out_stage (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  spa_pkg::t_result              i_result,
    output logic                          o_can_load,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [spa_pkg::STATUS_W-1:0]  o_status,
    output logic signed [spa_pkg::COEF_W-1:0] o_out_coefficient,
    output logic [spa_pkg::EXP_W-1:0]     o_out_exponent,
    output logic                          o_last
);
    import spa_pkg::*;

    logic    r_valid;
    t_result r_result;

    // The slot is free when empty or when its item leaves this cycle.
    assign o_can_load = !r_valid || i_out_ready;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_result <= i_result;
        end
    end

    assign o_out_valid       = r_valid;
    assign o_status          = r_result.status;
    assign o_out_coefficient = r_result.coef;
    assign o_out_exponent    = r_result.expo;
    assign o_last            = r_result.last;

endmodule

>>> sv/spa_ctrl.sv
// Sequencer that searches, shifts, updates and dumps the term memory.
module spa_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [spa_pkg::MODE_W-1:0]   i_mode,
    input  logic [spa_pkg::COEF_W-1:0]   i_coef,
    input  logic [spa_pkg::EXP_W-1:0]    i_expo,
    output spa_pkg::t_mem_req            o_mem_req,
    input  spa_pkg::t_term               i_rdata,
    input  logic                         i_can_load,
    output logic                         o_res_load,
    output spa_pkg::t_result             o_result
);
    import spa_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_EMIT   = 8'b0000_0010,
        ST_S_RD   = 8'b0000_0100,
        ST_S_CMP  = 8'b0000_1000,
        ST_SH_CHK = 8'b0001_0000,
        ST_SH_WR  = 8'b0010_0000,
        ST_D_RD   = 8'b0100_0000,
        ST_D_OUT  = 8'b1000_0000
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_pos, n_pos;
    logic [CNT_W-1:0]  r_sh, n_sh;
    logic [COEF_W-1:0] r_coef, n_coef;
    logic [EXP_W-1:0]  r_expo, n_expo;
    t_status           r_pend, n_pend;
    logic [CNT_W-1:0]  w_pos_inc;
    logic [CNT_W-1:0]  w_sh_dec;
    logic              w_full;

    assign w_pos_inc  = r_pos + CNT_W'(1);
    assign w_sh_dec   = r_sh - CNT_W'(1);
    assign w_full     = (r_count == CNT_W'(MAX_TERMS));
    assign o_in_ready = (r_state == ST_IDLE);

    // Next-state and memory request logic.
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_pos      = r_pos;
        n_sh       = r_sh;
        n_coef     = r_coef;
        n_expo     = r_expo;
        n_pend     = r_pend;
        o_mem_req  = '0;
        o_res_load = 1'b0;
        o_result   = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_coef = i_coef;
                    n_expo = i_expo;
                    unique case (t_mode'(i_mode))
                        MODE_ADD: begin
                            if (r_count == '0) begin
                                // Empty table: the term goes straight to the front.
                                o_mem_req.we    = 1'b1;
                                o_mem_req.waddr = '0;
                                o_mem_req.wdata = '{expo: i_expo, coef: i_coef};
                                n_count = CNT_W'(1);
                                n_pend  = STAT_ADDED;
                                n_state = ST_EMIT;
                            end else begin
                                n_pos   = '0;
                                n_state = ST_S_RD;
                            end
                        end
                        MODE_CLEAR: begin
                            n_count = '0;
                            n_pend  = STAT_CLEARED;
                            n_state = ST_EMIT;
                        end
                        MODE_DUMP: begin
                            if (r_count == '0) begin
                                n_pend  = STAT_EMPTY;
                                n_state = ST_EMIT;
                            end else begin
                                n_pos   = '0;
                                n_state = ST_D_RD;
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_EMIT: begin
                // Single result of an add or clear, or the empty dump.
                if (i_can_load) begin
                    o_res_load      = 1'b1;
                    o_result.status = r_pend;
                    o_result.last   = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            ST_S_RD: begin
                o_mem_req.re    = 1'b1;
                o_mem_req.raddr = r_pos[IDX_W-1:0];
                n_state         = ST_S_CMP;
            end
            ST_S_CMP: begin
                if (i_rdata.expo == r_expo) begin
                    // Exponent present: accumulate in place.
                    o_mem_req.we    = 1'b1;
                    o_mem_req.waddr = r_pos[IDX_W-1:0];
                    o_mem_req.wdata = '{expo: r_expo, coef: i_rdata.coef + r_coef};
                    n_pend  = STAT_ADDED;
                    n_state = ST_EMIT;
                end else if (i_rdata.expo < r_expo && w_pos_inc != r_count) begin
                    n_pos   = w_pos_inc;
                    n_state = ST_S_RD;
                end else if (w_full) begin
                    n_pend  = STAT_FULL;
                    n_state = ST_EMIT;
                end else begin
                    // Insert point found; open a gap from the top down.
                    n_pos   = (i_rdata.expo < r_expo) ? w_pos_inc : r_pos;
                    n_sh    = r_count;
                    n_state = ST_SH_CHK;
                end
            end
            ST_SH_CHK: begin
                if (r_sh == r_pos) begin
                    o_mem_req.we    = 1'b1;
                    o_mem_req.waddr = r_pos[IDX_W-1:0];
                    o_mem_req.wdata = '{expo: r_expo, coef: r_coef};
                    n_count = r_count + CNT_W'(1);
                    n_pend  = STAT_ADDED;
                    n_state = ST_EMIT;
                end else begin
                    o_mem_req.re    = 1'b1;
                    o_mem_req.raddr = w_sh_dec[IDX_W-1:0];
                    n_state         = ST_SH_WR;
                end
            end
            ST_SH_WR: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_sh[IDX_W-1:0];
                o_mem_req.wdata = i_rdata;
                n_sh            = w_sh_dec;
                n_state         = ST_SH_CHK;
            end
            ST_D_RD: begin
                o_mem_req.re    = 1'b1;
                o_mem_req.raddr = r_pos[IDX_W-1:0];
                n_state         = ST_D_OUT;
            end
            ST_D_OUT: begin
                // Read data holds while the output slot is busy.
                if (i_can_load) begin
                    o_res_load      = 1'b1;
                    o_result.status = STAT_TERM;
                    o_result.coef   = i_rdata.coef;
                    o_result.expo   = i_rdata.expo;
                    o_result.last   = (w_pos_inc == r_count);
                    if (w_pos_inc == r_count) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_pos   = w_pos_inc;
                        n_state = ST_D_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_sh   <= n_sh;
        r_coef <= n_coef;
        r_expo <= n_expo;
        r_pend <= n_pend;
    end

endmodule

>>> sv/sparse_polynomial_accumulator.sv
// Top level of the sparse polynomial accumulator.
//
//   Channel | Handshake                   | Payload
//   --------+-----------------------------+-----------------------------------------
//   input   | i_in_valid / o_in_ready     | i_mode, i_term_coefficient, i_term_exponent
//   output  | o_out_valid / i_out_ready   | o_status, o_out_coefficient,
//           |                             | o_out_exponent, o_last
//
// An add reads and compares the stored terms one by one, in the order of their
// exponents, until it finds its own exponent, which it accumulates in place, or its
// insert point; there it moves the terms above up one place each to open a gap, or
// drops the term when the table is full. The search and the move are paced by the
// single read port of the term memory. An empty table takes the term at the front.
// Reset empties the table at once; the memory itself is not cleared.
// A busy output slot stalls the sequencer in place; no item is taken until the
// current one has handed over all of its results.
module sparse_polynomial_accumulator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [spa_pkg::MODE_W-1:0]        i_mode,
    input  logic signed [spa_pkg::COEF_W-1:0] i_term_coefficient,
    input  logic [spa_pkg::EXP_W-1:0]         i_term_exponent,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [spa_pkg::STATUS_W-1:0]      o_status,
    output logic signed [spa_pkg::COEF_W-1:0] o_out_coefficient,
    output logic [spa_pkg::EXP_W-1:0]         o_out_exponent,
    output logic                              o_last
);
    import spa_pkg::*;

    t_mem_req w_mem_req;
    t_term    w_rdata;
    logic     w_can_load;
    logic     w_res_load;
    t_result  w_result;

    // Sequencer.
    spa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_mode     (i_mode),
        .i_coef     (i_term_coefficient),
        .i_expo     (i_term_exponent),
        .o_mem_req  (w_mem_req),
        .i_rdata    (w_rdata),
        .i_can_load (w_can_load),
        .o_res_load (w_res_load),
        .o_result   (w_result)
    );

    // Term table.
    spa_term_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (w_mem_req),
        .o_rdata (w_rdata)
    );

    // Output register.
    spa_out_stage u_out (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_load            (w_res_load),
        .i_result          (w_result),
        .o_can_load        (w_can_load),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_status          (o_status),
        .o_out_coefficient (o_out_coefficient),
        .o_out_exponent    (o_out_exponent),
        .o_last            (o_last)
    );

endmodule

>>> sv/spa_checker.sv
// Port-level checks for the sparse polynomial accumulator, bound to its top level.
module spa_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_ready,
    input logic [spa_pkg::MODE_W-1:0]        i_mode,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic [spa_pkg::STATUS_W-1:0]      o_status,
    input logic signed [spa_pkg::COEF_W-1:0] o_out_coefficient,
    input logic [spa_pkg::EXP_W-1:0]         o_out_exponent,
    input logic                              o_last
);
    import spa_pkg::*;

    // A pending result item stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result item dropped while stalled");

    // Results other than dumped terms carry zero payload.
    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != STAT_TERM |->
            o_out_coefficient == '0 && o_out_exponent == '0)
        else $error("non-term result with nonzero payload");

    // Results other than dumped terms are always the last of their item.
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != STAT_TERM |-> o_last)
        else $error("non-term result without last marker");

    // An accepted operation item blocks the input until it is finished.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_mode != MODE_NONE |=> !o_in_ready)
        else $error("input taken while an item is in progress");

    // No result item is offered right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered after reset");

endmodule

bind sparse_polynomial_accumulator spa_checker u_spa_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_ready        (o_in_ready),
    .i_mode            (i_mode),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_status          (o_status),
    .o_out_coefficient (o_out_coefficient),
    .o_out_exponent    (o_out_exponent),
    .o_last            (o_last)
);
